>>> hw/rtl/kmp_stream_matcher_unit_macros.svh
// ----------------------------------------------------------------------------
// KMP stream matcher assertion macros
// Clocked assertion helpers shared by the matcher RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef KMP_STREAM_MATCHER_UNIT_MACROS_SVH
`define KMP_STREAM_MATCHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define KMP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kmp matcher: implication check failed");
// Next-cycle implication
`define KMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kmp matcher: next-cycle check failed");
`else
`define KMP_ASSERT_IMPLIES(label, ante, cons)
`define KMP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// KMP matcher package
// Default sizes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kmp_pkg;

    // Default pattern capacity in bytes
    localparam int PATTERN_MAX_DEFAULT = 64;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture an input beat and apply new-pattern/new-text clears
        logic lookup;  // read pattern and link memories at the current matched length
        logic step;    // mismatch: follow the failure link and read at the new length
        logic hit;     // byte matched: extend the matched length by one
        logic finish;  // commit the item: store pattern byte or update text state
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic trivial;   // item needs no failure walk
        logic hit;       // pattern byte read back equals the item byte
        logic k_zero;    // matched length is zero
        logic is_match;  // text byte completes a full occurrence
        logic out_block; // completing match while the result register is full and stalled
    } t_dp_status;

endpackage

>>> hw/rtl/kmp_ctrl.sv
// ----------------------------------------------------------------------------
// KMP matcher controller
// Sequences one item at a time: capture, failure-link walk, commit.
// ----------------------------------------------------------------------------
module kmp_ctrl
    import kmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMPARE,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (i_sts.trivial) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.lookup = 1'b1;
                    n_state      = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                if (i_sts.hit) begin
                    o_cmd.hit = 1'b1;
                    n_state   = ST_FINISH;
                end else if (i_sts.k_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!i_sts.out_block) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Take a new beat only when idle
    assign o_in_stall = (r_state != ST_IDLE);

endmodule

>>> hw/rtl/kmp_dp.sv
// ----------------------------------------------------------------------------
// KMP matcher datapath
// Pattern and link memories, matched-length and position registers, result register.
// ----------------------------------------------------------------------------
module kmp_dp
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_sts,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_match_start
);

    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(PATTERN_MAX);

    logic [7:0]    mem_store  [PATTERN_MAX];
    logic [LW-1:0] mem_prefix [PATTERN_MAX];

    logic          r_mode;
    logic [7:0]    r_c;
    logic [LW-1:0] r_plen;
    logic [LW-1:0] r_mlen;
    logic [31:0]   r_pos;
    logic [LW-1:0] r_k;
    logic [LW-1:0] r_last_link;
    logic [7:0]    r_store_rd;
    logic [LW-1:0] r_prefix_rd;
    logic          r_out_valid;
    logic [31:0]   r_match_start;

    logic [LW-1:0] rd_k;
    logic [LW-1:0] rd_k_m1;
    logic          plen_full;
    logic          is_match;

    // Walk address: current length, or the link just read on a mismatch
    assign rd_k    = i_cmd.step ? r_prefix_rd : r_k;
    assign rd_k_m1 = rd_k - LW'(1);

    assign plen_full = (r_plen == LEN_MAX);
    assign is_match  = r_mode && (r_plen != '0) && (r_k == r_plen);

    // Status to the controller
    always_comb begin
        o_sts.trivial   = (r_plen == '0) || (!r_mode && plen_full);
        o_sts.hit       = (r_store_rd == r_c);
        o_sts.k_zero    = (r_k == '0);
        o_sts.is_match  = is_match;
        o_sts.out_block = is_match && r_out_valid && i_out_stall;
    end

    // Read both memories every cycle, data registered
    always_ff @(posedge i_clk) begin
        r_store_rd  <= mem_store[rd_k[AW-1:0]];
        r_prefix_rd <= mem_prefix[rd_k_m1[AW-1:0]];
    end

    // Append a pattern byte and its link
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && !r_mode && !plen_full) begin
            mem_store[r_plen[AW-1:0]]  <= r_c;
            mem_prefix[r_plen[AW-1:0]] <= r_k;
        end
    end

    // Capture beat, walk links, commit item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_plen      <= '0;
            r_mlen      <= '0;
            r_pos       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_mode <= i_mode;
                r_c    <= i_data_byte;
                if (!i_mode) begin
                    if (i_first) begin
                        r_plen <= '0;
                        r_mlen <= '0;
                    end
                    r_k <= (i_first || (r_plen == '0)) ? '0 : r_last_link;
                end else begin
                    if (i_first) begin
                        r_mlen <= '0;
                        r_pos  <= '0;
                    end
                    r_k <= i_first ? '0 : r_mlen;
                end
            end else if (i_cmd.hit) begin
                r_k <= r_k + LW'(1);
            end else if (i_cmd.step) begin
                r_k <= r_prefix_rd;
            end

            if (i_cmd.finish) begin
                if (!r_mode) begin
                    if (!plen_full) begin
                        r_last_link <= r_k;
                        r_plen      <= r_plen + LW'(1);
                    end
                end else begin
                    r_pos <= r_pos + 32'd1;
                    if (r_plen == '0) begin
                        r_mlen <= '0;
                    end else if (is_match) begin
                        r_mlen <= r_last_link;
                    end else begin
                        r_mlen <= r_k;
                    end
                end
            end

            // Load a result, or drop it once taken
            if (i_cmd.finish && is_match) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Occurrence start: position of last byte minus pattern length plus one
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && is_match) begin
            r_match_start <= r_pos - 32'(r_plen - LW'(1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_start = r_match_start;

endmodule

>>> hw/rtl/kmp_stream_matcher_unit.sv
// ----------------------------------------------------------------------------
// KMP stream matcher unit
// Streaming Knuth-Morris-Pratt matcher: pattern load with incremental links,
// then text matching that reports the start position of each occurrence.
// ----------------------------------------------------------------------------
// One item is in work at a time. A dropped pattern byte, the first byte of a
// pattern and any text byte while the pattern is empty skip the failure-link
// walk and go from capture through lookup to commit. Every other item adds a
// compare step for each of the n byte comparisons of its failure-link walk,
// as the memories have registered reads. Over a stream, n averages at most
// two per byte. A result waits in an output register and does not block the
// next input beat; only a completing match against a full, stalled result
// register holds the unit. Pattern and link memories need no clearing pass.
// ----------------------------------------------------------------------------
`include "kmp_stream_matcher_unit_macros.svh"

module kmp_stream_matcher_unit
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_match_start
);

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;

    // Sequencer
    kmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Memories and matcher registers
    kmp_dp #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_mode),
        .i_data_byte   (i_data_byte),
        .i_first       (i_first),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_match_start (o_match_start)
    );

    // A committed match never overwrites a result still waiting
    `KMP_ASSERT_IMPLIES(a_no_overwrite, w_cmd.finish && w_sts.is_match, !o_out_valid || !i_out_stall)
    // A committed match shows up as a result beat
    `KMP_ASSERT_NEXT(a_match_shown, w_cmd.finish && w_sts.is_match, o_out_valid)
    // A captured beat keeps the input side stalled while it is in work
    `KMP_ASSERT_NEXT(a_busy_after_load, w_cmd.load, o_in_stall)

endmodule
